// ----- hw/rtl/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/ptrq_pkg.sv -----
package ptrq_pkg;

  localparam int TASKS_DEF       = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int LOG_DEPTH_DEF   = 8;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_CREATE     = 3'd1,
    REQ_DELETE     = 3'd2,
    REQ_SET_DELAY  = 3'd3,
    REQ_SET_PERIOD = 3'd4,
    REQ_DISPATCH   = 3'd5,
    REQ_READ_LOG   = 3'd6
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ID   = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BAD_ID = 2'd1,
    ERR_EXISTS = 2'd2
  } err_code_t;

  // one task slot as held in the task table
  typedef struct packed {
    logic        active;
    logic [15:0] delay;
    logic [15:0] period;
  } task_ent_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  typedef struct packed {
    logic      wr;
    err_code_t code;
    logic [2:0] idx;
  } elog_cmd_t;

endpackage

// ----- hw/rtl/ptrq_if.sv -----
interface ptrq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  task_id;
  logic [15:0] delay_ticks;
  logic [15:0] period_ticks;
  logic [2:0]  log_index;

  modport source (
    output valid, req_type, task_id, delay_ticks, period_ticks, log_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_id, delay_ticks, period_ticks, log_index,
    output ready
  );
endinterface

interface ptrq_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       dispatched_valid;
  logic [3:0] dispatched_id;
  logic [4:0] released_count;
  logic [4:0] ready_count;
  logic       error_flag;
  logic [7:0] error_total;
  logic [1:0] log_code;

  modport source (
    output valid, status, dispatched_valid, dispatched_id, released_count,
           ready_count, error_flag, error_total, log_code,
    input  ready
  );
  modport sink (
    input  valid, status, dispatched_valid, dispatched_id, released_count,
           ready_count, error_flag, error_total, log_code,
    output ready
  );
endinterface

// ----- hw/rtl/periodic_task_release_queue_top.sv -----
// periodic task release queue
// requests come in on the req channel (valid/ready), one result per request
// leaves on the rsp channel (valid/ready); a request is taken only while the
// sequencer is idle, so one request is in flight at a time
// the task table (active, delay, period) lives in a one-port-read ram with a
// valid bit per slot, the ready ring and the error log in rams of their own
// states from accept to result valid:
//   tick               S_TICK, one slot read-modify-written per cycle
//   create .. read log S_OP, one table or log read then the write back
//   dispatch           S_DPOP, S_DWAIT, S_DCHK per ring entry popped, stale ids
//                      included, plus a last S_DPOP when the ring runs dry
// the next request is taken the cycle after its result is loaded into the
// output register, and the result may wait there while the next one runs
// reset clears all valid bits, ring pointers, the log fill and the counters
// at once; no clearing pass is needed
// when the receiver stalls, the finished result waits in the sequencer's
// last state until the output register frees up, and no request is taken
module periodic_task_release_queue_top #(
  parameter int TASKS       = ptrq_pkg::TASKS_DEF,
  parameter int QUEUE_DEPTH = ptrq_pkg::QUEUE_DEPTH_DEF,
  parameter int LOG_DEPTH   = ptrq_pkg::LOG_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  ptrq_req_if.sink   req,
  ptrq_rsp_if.source rsp
);

`include "assert_macros.svh"

  localparam int IDW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int RCW = $clog2(TASKS + 1);
  localparam int TEW = $bits(ptrq_pkg::task_ent_t);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TICK  = 7'b0000010,
    S_OP    = 7'b0000100,
    S_DPOP  = 7'b0001000,
    S_DWAIT = 7'b0010000,
    S_DCHK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // captured request
  ptrq_pkg::req_type_t r_type;
  logic [7:0]          r_id;
  logic [15:0]         r_dly;
  logic [15:0]         r_per;
  logic                bad_id;

  // sequencer registers
  logic [IDW-1:0] tick_slot;
  logic [IDW-1:0] tick_slot_next;
  logic [IDW-1:0] cand;
  logic [IDW-1:0] cand_next;

  // result being built
  ptrq_pkg::status_t   res_status;
  ptrq_pkg::status_t   res_status_next;
  logic                res_dvalid;
  logic                res_dvalid_next;
  logic [IDW-1:0]      res_did;
  logic [IDW-1:0]      res_did_next;
  logic [RCW-1:0]      res_rel;
  logic [RCW-1:0]      res_rel_next;
  ptrq_pkg::err_code_t res_lcode;
  ptrq_pkg::err_code_t res_lcode_next;

  // task table
  logic [IDW-1:0]      t_raddr;
  logic                t_we;
  logic [IDW-1:0]      t_waddr;
  ptrq_pkg::task_ent_t t_wdata;
  logic [TEW-1:0]      t_rdata;
  logic [TASKS-1:0]    t_vld;
  logic                t_vld_q;
  ptrq_pkg::task_ent_t t_ent;

  // ready ring
  ptrq_pkg::ring_cmd_t ring_cmd;
  logic [IDW-1:0]      ring_pop_id;
  logic [QFW-1:0]      ring_fill;
  logic                ring_full;
  logic                ring_empty;

  // error log
  ptrq_pkg::elog_cmd_t elog_cmd;
  ptrq_pkg::err_code_t elog_code;
  logic                err_seen;
  logic [7:0]          err_count;

  // output register
  logic       o_valid;
  logic       out_load;
  logic [2:0] o_status;
  logic       o_dvalid;
  logic [3:0] o_did;
  logic [4:0] o_rel;
  logic [4:0] o_fill;
  logic       o_flag;
  logic [7:0] o_total;
  logic [1:0] o_lcode;

  logic [IDW+3:0] did_ext;
  logic [RCW+4:0] rel_ext;
  logic [QFW+4:0] fill_ext;

  assign req.ready = (state == S_IDLE);
  assign bad_id    = (r_id >= 8'(TASKS));

  // ---------------------------------------------------------------------------
  // storage
  // ---------------------------------------------------------------------------

  ptrq_ram #(.WIDTH(TEW), .DEPTH(TASKS)) u_task_mem (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // a slot never written since reset reads as all zero
  assign t_ent = t_vld_q ? ptrq_pkg::task_ent_t'(t_rdata) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld   <= '0;
      t_vld_q <= 1'b0;
    end else begin
      t_vld_q <= t_vld[t_raddr];
      if (t_we) begin
        t_vld[t_waddr] <= 1'b1;
      end
    end
  end

  ptrq_ring #(.DEPTH(QUEUE_DEPTH), .IDW(IDW)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ring_cmd),
    .push_id (tick_slot),
    .pop_id  (ring_pop_id),
    .fill    (ring_fill),
    .full    (ring_full),
    .empty   (ring_empty)
  );

  ptrq_elog #(.DEPTH(LOG_DEPTH)) u_elog (
    .clk     (clk),
    .rst     (rst),
    .cmd     (elog_cmd),
    .rd_code (elog_code),
    .seen    (err_seen),
    .count   (err_count)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // the table is read in the cycle before its write back; during a tick the
  // write of slot n and the read of slot n+1 never hit the same entry, and
  // single-slot requests read in the accept cycle and write in the next one
  // ---------------------------------------------------------------------------

  always_comb begin
    state_next      = state;
    tick_slot_next  = tick_slot;
    cand_next       = cand;
    res_status_next = res_status;
    res_dvalid_next = res_dvalid;
    res_did_next    = res_did;
    res_rel_next    = res_rel;
    res_lcode_next  = res_lcode;
    t_raddr         = req.task_id[IDW-1:0];
    t_we            = 1'b0;
    t_waddr         = r_id[IDW-1:0];
    t_wdata         = t_ent;
    ring_cmd        = '0;
    elog_cmd.wr     = 1'b0;
    elog_cmd.code   = ptrq_pkg::ERR_NONE;
    elog_cmd.idx    = req.log_index;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_status_next = ptrq_pkg::ST_OK;
          res_dvalid_next = 1'b0;
          res_did_next    = '0;
          res_rel_next    = '0;
          res_lcode_next  = ptrq_pkg::ERR_NONE;
          tick_slot_next  = '0;
          unique case (ptrq_pkg::req_type_t'(req.req_type))
            ptrq_pkg::REQ_TICK: begin
              t_raddr    = '0;
              state_next = S_TICK;
            end
            ptrq_pkg::REQ_DISPATCH: begin
              res_status_next = ptrq_pkg::ST_EMPTY;
              state_next      = S_DPOP;
            end
            default: begin
              state_next = S_OP;
            end
          endcase
        end
      end

      S_TICK: begin
        t_raddr = tick_slot + IDW'(1);
        t_waddr = tick_slot;
        if (t_ent.active) begin
          t_we = 1'b1;
          if (t_ent.delay <= 16'd1) begin
            // due: reload, and release unless the ring is full
            t_wdata.delay = t_ent.period;
            if (!ring_full) begin
              ring_cmd.push = 1'b1;
              res_rel_next  = res_rel + RCW'(1);
            end else begin
              res_status_next = ptrq_pkg::ST_OVERFLOW;
            end
          end else begin
            t_wdata.delay = t_ent.delay - 16'd1;
          end
        end
        if (tick_slot == IDW'(TASKS - 1)) begin
          state_next = S_DONE;
        end else begin
          tick_slot_next = tick_slot + IDW'(1);
        end
      end

      S_OP: begin
        state_next = S_DONE;
        case (r_type)
          ptrq_pkg::REQ_CREATE, ptrq_pkg::REQ_DELETE,
          ptrq_pkg::REQ_SET_DELAY, ptrq_pkg::REQ_SET_PERIOD: begin
            if (bad_id) begin
              elog_cmd.wr     = 1'b1;
              elog_cmd.code   = ptrq_pkg::ERR_BAD_ID;
              res_status_next = ptrq_pkg::ST_BAD_ID;
            end else if (r_type == ptrq_pkg::REQ_CREATE) begin
              if (t_ent.active) begin
                elog_cmd.wr     = 1'b1;
                elog_cmd.code   = ptrq_pkg::ERR_EXISTS;
                res_status_next = ptrq_pkg::ST_EXISTS;
              end else begin
                t_we           = 1'b1;
                t_wdata.active = 1'b1;
                t_wdata.delay  = r_dly;
                t_wdata.period = r_per;
              end
            end else if (r_type == ptrq_pkg::REQ_DELETE) begin
              t_we    = 1'b1;
              t_wdata = '0;
            end else if (r_type == ptrq_pkg::REQ_SET_DELAY) begin
              t_we          = 1'b1;
              t_wdata.delay = r_dly;
            end else begin
              t_we           = 1'b1;
              t_wdata.period = r_per;
            end
          end
          ptrq_pkg::REQ_READ_LOG: begin
            res_lcode_next = elog_code;
          end
          default: begin
          end
        endcase
      end

      S_DPOP: begin
        if (ring_empty) begin
          state_next = S_DONE;
        end else begin
          ring_cmd.pop = 1'b1;
          state_next   = S_DWAIT;
        end
      end

      S_DWAIT: begin
        // popped id is out of the ring ram, look up its slot
        t_raddr    = ring_pop_id;
        cand_next  = ring_pop_id;
        state_next = S_DCHK;
      end

      S_DCHK: begin
        if (t_ent.active) begin
          res_status_next = ptrq_pkg::ST_OK;
          res_dvalid_next = 1'b1;
          res_did_next    = cand;
          state_next      = S_DONE;
        end else begin
          // stale id of a deleted task, keep popping
          state_next = S_DPOP;
        end
      end

      S_DONE: begin
        if (!o_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    tick_slot  <= tick_slot_next;
    cand       <= cand_next;
    res_status <= res_status_next;
    res_dvalid <= res_dvalid_next;
    res_did    <= res_did_next;
    res_rel    <= res_rel_next;
    res_lcode  <= res_lcode_next;
    if (req.valid && req.ready) begin
      r_type <= ptrq_pkg::req_type_t'(req.req_type);
      r_id   <= req.task_id;
      r_dly  <= req.delay_ticks;
      r_per  <= req.period_ticks;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------

  assign out_load = (state == S_DONE) && (!o_valid || rsp.ready);
  assign did_ext  = {4'b0, res_did};
  assign rel_ext  = {5'b0, res_rel};
  assign fill_ext = {5'b0, ring_fill};

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status <= res_status;
      o_dvalid <= res_dvalid;
      o_did    <= did_ext[3:0];
      o_rel    <= rel_ext[4:0];
      o_fill   <= fill_ext[4:0];
      o_flag   <= err_seen;
      o_total  <= err_count;
      o_lcode  <= res_lcode;
    end
  end

  assign rsp.valid            = o_valid;
  assign rsp.status           = o_status;
  assign rsp.dispatched_valid = o_dvalid;
  assign rsp.dispatched_id    = o_did;
  assign rsp.released_count   = o_rel;
  assign rsp.ready_count      = o_fill;
  assign rsp.error_flag       = o_flag;
  assign rsp.error_total      = o_total;
  assign rsp.log_code         = o_lcode;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  `ASSERT_IMPL(a_push_only_in_tick, clk, rst, ring_cmd.push, (state == S_TICK) && !ring_full)
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, req.valid && req.ready, state != S_IDLE)
  `ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, ring_fill <= QFW'(QUEUE_DEPTH))
  `ASSERT_IMPL(a_dispatch_ok, clk, rst, o_valid && o_dvalid, o_status == 3'(ptrq_pkg::ST_OK))

endmodule

// ----- hw/rtl/ptrq_ram.sv -----
module ptrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ptrq_ring.sv -----
module ptrq_ring #(
  parameter int DEPTH = ptrq_pkg::QUEUE_DEPTH_DEF,
  parameter int IDW = 4,
  localparam int FW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  ptrq_pkg::ring_cmd_t cmd,
  input  logic [IDW-1:0]      push_id,
  output logic [IDW-1:0]      pop_id,
  output logic [FW-1:0]       fill,
  output logic                full,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [FW-1:0] fill_next;

  // pop data shows up in the cycle after the pop
  ptrq_ram #(.WIDTH(IDW), .DEPTH(DEPTH)) u_ring_mem (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (head),
    .wdata (push_id),
    .raddr (tail),
    .rdata (pop_id)
  );

  assign full  = (fill == FW'(DEPTH));
  assign empty = (fill == '0);

  always_comb begin
    case ({cmd.push, cmd.pop})
      2'b10:   fill_next = fill + FW'(1);
      2'b01:   fill_next = fill - FW'(1);
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (cmd.push) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (cmd.pop) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/ptrq_elog.sv -----
module ptrq_elog #(
  parameter int DEPTH = ptrq_pkg::LOG_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ptrq_pkg::elog_cmd_t cmd,
  output ptrq_pkg::err_code_t rd_code,
  output logic                seen,
  output logic [7:0]          count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UW = $clog2(DEPTH + 1);

  // circular store: logical entry 0 sits at start once the log is full
  logic [PW-1:0]   start;
  logic [UW-1:0]   used;
  logic [PW-1:0]   waddr;
  logic [PW+3:0]   rsum;
  logic [PW-1:0]   raddr;
  logic            hit;
  logic            hit_q;
  logic [1:0]      rdata;
  logic            full;

  assign full  = (used == UW'(DEPTH));
  assign waddr = full ? start : used[PW-1:0];

  // wrap of start + index, only needed for indexes below the fill level
  assign rsum  = {4'b0, start} + {{PW{1'b0}}, 1'b0, cmd.idx};
  assign raddr = (rsum >= (PW + 4)'(DEPTH)) ? PW'(rsum - (PW + 4)'(DEPTH)) : rsum[PW-1:0];
  assign hit   = ({3'b0, used} > {{UW{1'b0}}, cmd.idx});

  ptrq_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_log_mem (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (waddr),
    .wdata (cmd.code),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_code = hit_q ? ptrq_pkg::err_code_t'(rdata) : ptrq_pkg::ERR_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      used  <= '0;
      seen  <= 1'b0;
      count <= '0;
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit;
      if (cmd.wr) begin
        seen <= 1'b1;
        if (count != 8'hff) begin
          count <= count + 8'd1;
        end
        if (full) begin
          start <= (start == PW'(DEPTH - 1)) ? '0 : start + PW'(1);
        end else begin
          used <= used + UW'(1);
        end
      end
    end
  end

endmodule

// ----- tb/periodic_task_release_queue_top_tb.sv -----
`timescale 1ns / 100ps

module periodic_task_release_queue_top_tb;

  localparam int TASKS       = ptrq_pkg::TASKS_DEF;
  localparam int QUEUE_DEPTH = ptrq_pkg::QUEUE_DEPTH_DEF;
  localparam int LOG_DEPTH   = ptrq_pkg::LOG_DEPTH_DEF;

  // request code that the block must ignore
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam int RANDOM_REQUESTS = 1725;
  localparam int IDLE_PERCENT    = 38;
  // no-idle stretch, counted in requests sent
  localparam int STEADY_FIRST    = 700;
  localparam int STEADY_LAST     = 1000;
  // a dispatch may pop the whole ring
  localparam int DRAIN_CYCLES    = 80;
  localparam int QUIET_LIMIT     = 2000;

  // one request as it crosses the req channel
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  task_id;
    logic [15:0] delay_ticks;
    logic [15:0] period_ticks;
    logic [2:0]  log_index;
  } sched_request_t;

  // one answer as it crosses the rsp channel
  typedef struct {
    ptrq_pkg::status_t   status;
    logic                dispatched_valid;
    logic [3:0]          dispatched_id;
    logic [4:0]          released_count;
    logic [4:0]          ready_count;
    logic                error_flag;
    logic [7:0]          error_total;
    ptrq_pkg::err_code_t log_code;
  } sched_answer_t;

  // shadow of the scheduler: task table, ready ring and error log, plus the
  // answers still owed by the block
  class release_tracker;
    logic                task_on [TASKS];
    logic [15:0]         task_dly [TASKS];
    logic [15:0]         task_per [TASKS];
    logic [3:0]          ring_ids [QUEUE_DEPTH];
    int                  ring_head;
    int                  ring_tail;
    int                  ring_fill;
    ptrq_pkg::err_code_t err_log [LOG_DEPTH];
    int                  err_count;
    logic                err_seen;
    sched_answer_t       awaited_answers [$];
    int                  failures;

    function new();
      for (int t = 0; t < TASKS; t++) begin
        task_on[t]  = 1'b0;
        task_dly[t] = '0;
        task_per[t] = '0;
      end
      for (int q = 0; q < QUEUE_DEPTH; q++) ring_ids[q] = '0;
      for (int k = 0; k < LOG_DEPTH; k++) err_log[k] = ptrq_pkg::ERR_NONE;
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;
      err_count = 0;
      err_seen  = 1'b0;
      failures  = 0;
    endfunction

    // full log drops its oldest entry, count saturates
    function void log_error(ptrq_pkg::err_code_t code);
      err_seen = 1'b1;
      if (err_count >= LOG_DEPTH) begin
        for (int k = 0; k < LOG_DEPTH - 1; k++) err_log[k] = err_log[k + 1];
        err_log[LOG_DEPTH - 1] = code;
      end else begin
        err_log[err_count] = code;
      end
      if (err_count < 255) err_count++;
    endfunction

    function void note_request(sched_request_t r);
      sched_answer_t a;
      int            slot;
      int            cand;
      logic          addressed;
      a.status           = ptrq_pkg::ST_OK;
      a.dispatched_valid = 1'b0;
      a.dispatched_id    = '0;
      a.released_count   = '0;
      a.log_code         = ptrq_pkg::ERR_NONE;
      slot = r.task_id;
      addressed = (r.kind == ptrq_pkg::REQ_CREATE) || (r.kind == ptrq_pkg::REQ_DELETE) ||
                  (r.kind == ptrq_pkg::REQ_SET_DELAY) ||
                  (r.kind == ptrq_pkg::REQ_SET_PERIOD);
      if (addressed && slot >= TASKS) begin
        log_error(ptrq_pkg::ERR_BAD_ID);
        a.status = ptrq_pkg::ST_BAD_ID;
      end else begin
        case (r.kind)
          ptrq_pkg::REQ_TICK: begin
            for (int t = 0; t < TASKS; t++) begin
              if (task_on[t]) begin
                if (task_dly[t] <= 16'd1) begin
                  if (ring_fill < QUEUE_DEPTH) begin
                    ring_ids[ring_head] = t[3:0];
                    ring_head = (ring_head + 1) % QUEUE_DEPTH;
                    ring_fill++;
                    a.released_count++;
                  end else begin
                    a.status = ptrq_pkg::ST_OVERFLOW;
                  end
                  task_dly[t] = task_per[t];
                end else begin
                  task_dly[t]--;
                end
              end
            end
          end
          ptrq_pkg::REQ_CREATE: begin
            if (task_on[slot]) begin
              log_error(ptrq_pkg::ERR_EXISTS);
              a.status = ptrq_pkg::ST_EXISTS;
            end else begin
              task_on[slot]  = 1'b1;
              task_dly[slot] = r.delay_ticks;
              task_per[slot] = r.period_ticks;
            end
          end
          ptrq_pkg::REQ_DELETE: begin
            task_on[slot]  = 1'b0;
            task_dly[slot] = '0;
            task_per[slot] = '0;
          end
          ptrq_pkg::REQ_SET_DELAY:  task_dly[slot] = r.delay_ticks;
          ptrq_pkg::REQ_SET_PERIOD: task_per[slot] = r.period_ticks;
          ptrq_pkg::REQ_DISPATCH: begin
            a.status = ptrq_pkg::ST_EMPTY;
            while (ring_fill > 0) begin
              cand = ring_ids[ring_tail];
              ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
              ring_fill--;
              if (task_on[cand]) begin
                a.status           = ptrq_pkg::ST_OK;
                a.dispatched_valid = 1'b1;
                a.dispatched_id    = cand[3:0];
                break;
              end
            end
          end
          ptrq_pkg::REQ_READ_LOG: begin
            if (r.log_index < LOG_DEPTH) a.log_code = err_log[r.log_index];
          end
          default: ;
        endcase
      end
      a.ready_count = ring_fill[4:0];
      a.error_flag  = err_seen;
      a.error_total = err_count[7:0];
      awaited_answers.push_back(a);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_answer(sched_answer_t got);
      sched_answer_t want;
      if (awaited_answers.size() == 0) begin
        $error("answer with no request outstanding");
        failures++;
        return;
      end
      want = awaited_answers.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("dispatched_valid", want.dispatched_valid, got.dispatched_valid);
      compare_field("dispatched_id", want.dispatched_id, got.dispatched_id);
      compare_field("released_count", want.released_count, got.released_count);
      compare_field("ready_count", want.ready_count, got.ready_count);
      compare_field("error_flag", want.error_flag, got.error_flag);
      compare_field("error_total", want.error_total, got.error_total);
      compare_field("log_code", want.log_code, got.log_code);
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  // high during the no-idle stretch, read by both channel drivers
  logic steady;
  int   sent;
  int   quiet_cycles;

  release_tracker tracker;

  ptrq_req_if req_ch ();
  ptrq_rsp_if rsp_ch ();

  periodic_task_release_queue_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sink side: random backpressure on answers, plus the stall watchdog
  always @(posedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // every answer taken by the sink is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_answer('{ptrq_pkg::status_t'(rsp_ch.status), rsp_ch.dispatched_valid,
                             rsp_ch.dispatched_id, rsp_ch.released_count,
                             rsp_ch.ready_count, rsp_ch.error_flag,
                             rsp_ch.error_total,
                             ptrq_pkg::err_code_t'(rsp_ch.log_code)});
    end
  end

  // mostly short delays so tasks keep firing, now and then a full 16-bit one
  function automatic logic [15:0] short_ticks();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4));
  endfunction

  // drive one request, with random idle cycles ahead of it, and hold it until
  // the block takes it; valid is left high until the next call drives it
  task automatic issue(input logic [2:0] kind, input logic [7:0] id,
                       input logic [15:0] dly, input logic [15:0] per,
                       input logic [2:0] lidx);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.task_id      <= id;
    req_ch.delay_ticks  <= dly;
    req_ch.period_ticks <= per;
    req_ch.log_index    <= lidx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request('{kind, id, dly, per, lidx});
    sent++;
  endtask

  // request with random values in every field but the kind
  task automatic issue_bare(input logic [2:0] kind);
    issue(kind, 8'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
  endtask

  initial begin
    int pick;
    int burst;
    clk                 = 1'b0;
    rst                 = 1'b1;
    steady              = 1'b0;
    sent                = 0;
    quiet_cycles        = 0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = ptrq_pkg::REQ_TICK;
    req_ch.task_id      = '0;
    req_ch.delay_ticks  = '0;
    req_ch.period_ticks = '0;
    req_ch.log_index    = '0;
    rsp_ch.ready        = 1'b0;
    tracker = new();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty log and ring, ignored code, rejected ids
    issue(ptrq_pkg::REQ_READ_LOG, 8'd0, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0);
    issue(REQ_UNUSED, 8'd255, 16'hFFFF, 16'hFFFF, 3'd7);
    issue(ptrq_pkg::REQ_CREATE, 8'd255, 16'd5, 16'd5, 3'd0);
    issue(ptrq_pkg::REQ_DELETE, 8'd16, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_SET_DELAY, 8'd128, 16'd3, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_SET_PERIOD, 8'd17, 16'd0, 16'd3, 3'd0);
    // zero delay and period behave as one tick
    issue(ptrq_pkg::REQ_CREATE, 8'd0, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_CREATE, 8'd0, 16'd7, 16'd7, 3'd0);
    issue(ptrq_pkg::REQ_CREATE, 8'd15, 16'hFFFF, 16'hFFFF, 3'd0);
    issue(ptrq_pkg::REQ_SET_DELAY, 8'd15, 16'd1, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_SET_PERIOD, 8'd15, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 3'd0);
    // deleted task left in the ring gets skipped by dispatch
    issue(ptrq_pkg::REQ_DELETE, 8'd0, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_DISPATCH, 8'd0, 16'd0, 16'd0, 3'd0);
    // push the log past full so its oldest entry falls out
    issue(ptrq_pkg::REQ_CREATE, 8'd200, 16'd1, 16'd1, 3'd0);
    issue(ptrq_pkg::REQ_DELETE, 8'd255, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_SET_DELAY, 8'd99, 16'd1, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_CREATE, 8'd15, 16'd1, 16'd1, 3'd0);
    issue(ptrq_pkg::REQ_READ_LOG, 8'd0, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_READ_LOG, 8'd0, 16'd0, 16'd0, 3'd7);
    issue(ptrq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 3'd0);
    issue(ptrq_pkg::REQ_SET_PERIOD, 8'd15, 16'd0, 16'hFFFF, 3'd0);

    // random part built from short episodes: populate, tick bursts, drains,
    // deletes and retiming, log reads, and unconstrained noise
    while (sent < RANDOM_REQUESTS) begin
      steady = (sent >= STEADY_FIRST) && (sent < STEADY_LAST);
      pick   = $urandom_range(0, 99);
      burst  = $urandom_range(1, 6);
      if (pick < 20) begin
        repeat (burst) issue(ptrq_pkg::REQ_CREATE, 8'($urandom_range(0, TASKS - 1)),
                             short_ticks(), short_ticks(), 3'($urandom));
      end else if (pick < 45) begin
        repeat (burst) issue_bare(ptrq_pkg::REQ_TICK);
      end else if (pick < 65) begin
        repeat (burst) issue_bare(ptrq_pkg::REQ_DISPATCH);
      end else if (pick < 77) begin
        case ($urandom_range(0, 2))
          0:       issue(ptrq_pkg::REQ_DELETE, 8'($urandom_range(0, TASKS - 1)),
                         16'($urandom), 16'($urandom), 3'($urandom));
          1:       issue(ptrq_pkg::REQ_SET_DELAY, 8'($urandom_range(0, TASKS - 1)),
                         short_ticks(), 16'($urandom), 3'($urandom));
          default: issue(ptrq_pkg::REQ_SET_PERIOD, 8'($urandom_range(0, TASKS - 1)),
                         16'($urandom), short_ticks(), 3'($urandom));
        endcase
      end else if (pick < 82) begin
        issue_bare(ptrq_pkg::REQ_READ_LOG);
      end else begin
        issue_bare(3'($urandom_range(0, 7)));
      end
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    // let every owed answer arrive, then watch for strays
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
